[rtl/ils_pkg.sv]
package ils_pkg;

  // List geometry
  localparam int Depth = 16;
  localparam int ElemWidth = 32;
  localparam int IdxWidth = $clog2(Depth);
  localparam int CntWidth = $clog2(Depth + 1);
  localparam int PosWidth = 5;
  // Width that holds both a position and a count for compares
  localparam int CmpWidth = (CntWidth > PosWidth) ? CntWidth : PosWidth;

  // Action codes
  localparam logic [1:0] ActPush = 2'd0;
  localparam logic [1:0] ActPop = 2'd1;
  localparam logic [1:0] ActInsert = 2'd2;
  localparam logic [1:0] ActRead = 2'd3;

  // Status codes
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StRange = 2'd3;

  typedef struct packed {
    logic [1:0]          action;
    logic [31:0]         value;
    logic [PosWidth-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [4:0]  entry_count;
    logic        is_empty;
  } result_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                 wr_en;
    logic                 shift_en;
    logic                 rd_en;
    logic [IdxWidth-1:0]  wr_idx;
    logic [IdxWidth-1:0]  rd_idx;
    logic [CntWidth-1:0]  cnt;
    logic [ElemWidth-1:0] value;
  } cell_ctl_t;

endpackage

[rtl/ils_cell.sv]
module ils_cell (
  input  logic                          clk_i,
  input  logic [ils_pkg::IdxWidth-1:0]  idx_i,
  input  ils_pkg::cell_ctl_t            ctl_i,
  input  logic [ils_pkg::ElemWidth-1:0] prev_i,
  output logic [ils_pkg::ElemWidth-1:0] data_o,
  output logic [ils_pkg::ElemWidth-1:0] rd_o
);

  logic [ils_pkg::ElemWidth-1:0] data_q;
  logic [ils_pkg::CntWidth-1:0]  idx_ext;
  logic                          take_prev;
  logic                          take_new;

  assign idx_ext = ils_pkg::CntWidth'(idx_i);

  // Shift up from the lower neighbor for cells above the insert point up to the count
  assign take_prev = ctl_i.shift_en && (idx_i > ctl_i.wr_idx) && (idx_ext <= ctl_i.cnt);
  assign take_new  = ctl_i.wr_en && (idx_i == ctl_i.wr_idx);

  // Hold the entry unless shifted or written
  always_ff @(posedge clk_i) begin
    if (take_prev) begin
      data_q <= prev_i;
    end else if (take_new) begin
      data_q <= ctl_i.value;
    end
  end

  assign data_o = data_q;

  // Drive the entry onto the read bus only when addressed
  assign rd_o = (ctl_i.rd_en && (idx_i == ctl_i.rd_idx)) ? data_q : '0;

endmodule

[rtl/indexed_list_store.sv]
// A command accepted at a clock edge gives its result, with done_o high,
// in the following cycle.
// Throughput: one command per cycle; busy_o stays low, since every action, an insert
// included, is applied to all the entry cells of the row in parallel.
// Reset: rst_ni clears the entry count and the result strobe; entry contents are
// not cleared and are only read after being written. The receiver cannot stall.
module indexed_list_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  ils_pkg::cmd_t    cmd_i,
  output logic             busy_o,
  output logic             done_o,
  output ils_pkg::result_t result_o
);

  logic [ils_pkg::CntWidth-1:0]  count_q, count_d;
  logic                          done_q;
  ils_pkg::result_t              result_q, result_d;
  ils_pkg::cell_ctl_t            ctl;
  logic                          accept;
  logic                          full;
  logic                          empty;
  logic [ils_pkg::CmpWidth-1:0]  pos_ext;
  logic [ils_pkg::CmpWidth-1:0]  cnt_ext;
  logic [1:0]                    status;
  logic [ils_pkg::ElemWidth-1:0] rd_or;

  logic [ils_pkg::ElemWidth-1:0] cell_data [ils_pkg::Depth];
  logic [ils_pkg::ElemWidth-1:0] cell_rd [ils_pkg::Depth];

  // No action ever stalls
  assign busy_o = 1'b0;
  assign accept = start_i;

  assign full    = (count_q == ils_pkg::CntWidth'(ils_pkg::Depth));
  assign empty   = (count_q == '0);
  assign pos_ext = ils_pkg::CmpWidth'(cmd_i.position);
  assign cnt_ext = ils_pkg::CmpWidth'(count_q);

  // Decode the action into cell controls, status and next count
  always_comb begin
    status       = ils_pkg::StOk;
    count_d      = count_q;
    ctl.wr_en    = 1'b0;
    ctl.shift_en = 1'b0;
    ctl.rd_en    = 1'b0;
    ctl.wr_idx   = '0;
    ctl.rd_idx   = '0;
    ctl.cnt      = count_q;
    ctl.value    = ils_pkg::ElemWidth'(cmd_i.value);
    unique case (cmd_i.action)
      ils_pkg::ActPush: begin
        if (full) begin
          status = ils_pkg::StFull;
        end else begin
          ctl.wr_en  = accept;
          ctl.wr_idx = ils_pkg::IdxWidth'(count_q);
          count_d    = count_q + ils_pkg::CntWidth'(1);
        end
      end
      ils_pkg::ActPop: begin
        if (empty) begin
          status = ils_pkg::StEmpty;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_idx = ils_pkg::IdxWidth'(count_q - ils_pkg::CntWidth'(1));
          count_d    = count_q - ils_pkg::CntWidth'(1);
        end
      end
      ils_pkg::ActInsert: begin
        if (pos_ext > cnt_ext) begin
          status = ils_pkg::StRange;
        end else if (full) begin
          status = ils_pkg::StFull;
        end else begin
          ctl.wr_en    = accept;
          ctl.shift_en = accept;
          ctl.wr_idx   = ils_pkg::IdxWidth'(cmd_i.position);
          count_d      = count_q + ils_pkg::CntWidth'(1);
        end
      end
      ils_pkg::ActRead: begin
        if (pos_ext >= cnt_ext) begin
          status = ils_pkg::StRange;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_idx = ils_pkg::IdxWidth'(cmd_i.position);
        end
      end
      default: begin
        status = ils_pkg::StOk;
      end
    endcase
  end

  // Row of entry cells, each handing its entry to the next one up
  for (genvar g = 0; g < ils_pkg::Depth; g++) begin : g_cell
    logic [ils_pkg::ElemWidth-1:0] prev;
    if (g == 0) begin : g_first
      assign prev = ctl.value;
    end else begin : g_rest
      assign prev = cell_data[g-1];
    end
    ils_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (ils_pkg::IdxWidth'(g)),
      .ctl_i  (ctl),
      .prev_i (prev),
      .data_o (cell_data[g]),
      .rd_o   (cell_rd[g])
    );
  end

  // Merge the read bus; only the addressed cell drives nonzero data
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < ils_pkg::Depth; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // Assemble the result of this action
  always_comb begin
    result_d.status      = status;
    result_d.read_value  = 32'(rd_or);
    result_d.entry_count = 5'(count_d);
    result_d.is_empty    = (count_d == '0);
  end

  // Advance the count and the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Hold the result payload for its transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Every accepted command gives exactly one result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> done_o)
    else $error("accepted command gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> !done_o)
    else $error("result without a command");

  // The count never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ils_pkg::CntWidth'(ils_pkg::Depth))
    else $error("entry count past depth");

  // A failed action returns no data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status != ils_pkg::StOk) |-> (result_o.read_value == '0))
    else $error("data returned with a failing status");

  // A successful push grows the list by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && (cmd_i.action == ils_pkg::ActPush) && !full
      |=> (count_q == $past(count_q) + ils_pkg::CntWidth'(1)))
    else $error("push did not advance the count");

  // An empty status only comes from an empty list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status == ils_pkg::StEmpty) |-> (count_q == '0))
    else $error("empty status with stored entries");

endmodule
